// File: sv/ordered_array_edit_engine_assert.svh
// assertion macros for the ordered array edit engine
// expects clk and rst_n in the scope of use
`ifndef ORDERED_ARRAY_EDIT_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_EDIT_ENGINE_ASSERT_SVH

// same-cycle implication
`define OAEE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oaee assertion failed");

// next-cycle implication
`define OAEE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oaee assertion failed");

`endif

// File: sv/oaee_pkg.sv
// shared types, codes and microcode rom of the ordered array edit engine
// no dependencies
package oaee_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int UA_W  = 6;

  typedef logic [UA_W-1:0] ua_t;
  typedef logic [4:0]      act_t;
  typedef logic [3:0]      cond_t;

  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_VAL   = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;
  localparam logic [OP_W-1:0] OP_FIND      = 3'd6;
  localparam logic [OP_W-1:0] OP_REVERSE   = 3'd7;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  localparam act_t ACT_NOP            = 5'd0;
  localparam act_t ACT_EMIT_OK        = 5'd1;
  localparam act_t ACT_EMIT_BADPOS    = 5'd2;
  localparam act_t ACT_EMIT_FULL      = 5'd3;
  localparam act_t ACT_EMIT_NF        = 5'd4;
  localparam act_t ACT_EMIT_READ      = 5'd5;
  localparam act_t ACT_EMIT_FIND      = 5'd6;
  localparam act_t ACT_EMIT_FIND_LAST = 5'd7;
  localparam act_t ACT_SETUP_INS      = 5'd8;
  localparam act_t ACT_RD_IDX_M1      = 5'd9;
  localparam act_t ACT_WR_RD_DEC      = 5'd10;
  localparam act_t ACT_WR_VAL_INC     = 5'd11;
  localparam act_t ACT_SETUP_DEL      = 5'd12;
  localparam act_t ACT_RD_IDX_P1      = 5'd13;
  localparam act_t ACT_WR_RD_INC      = 5'd14;
  localparam act_t ACT_DEC_CNT        = 5'd15;
  localparam act_t ACT_CLR_SCAN       = 5'd16;
  localparam act_t ACT_RD_IDX         = 5'd17;
  localparam act_t ACT_CMP_INC        = 5'd18;
  localparam act_t ACT_SET_IDX_AT     = 5'd19;
  localparam act_t ACT_RD_POS         = 5'd20;
  localparam act_t ACT_MARK_INC       = 5'd21;
  localparam act_t ACT_INC_IDX        = 5'd22;
  localparam act_t ACT_SETUP_REV      = 5'd23;
  localparam act_t ACT_DEC_HI_RD_IDX  = 5'd24;
  localparam act_t ACT_SAVE_RD_HI     = 5'd25;
  localparam act_t ACT_WR_IDX_RD      = 5'd26;
  localparam act_t ACT_WR_HI_TMP_INC  = 5'd27;

  localparam cond_t C_NEVER         = 4'd0;
  localparam cond_t C_ALWAYS        = 4'd1;
  localparam cond_t C_FULL          = 4'd2;
  localparam cond_t C_INS_BAD       = 4'd3;
  localparam cond_t C_BADPOS        = 4'd4;
  localparam cond_t C_IDX_EQ_INS    = 4'd5;
  localparam cond_t C_IDX_P1_GE_CNT = 4'd6;
  localparam cond_t C_IDX_GE_CNT    = 4'd7;
  localparam cond_t C_NOHIT         = 4'd8;
  localparam cond_t C_NOMATCH       = 4'd9;
  localparam cond_t C_REV_DONE      = 4'd10;

  localparam ua_t U_IDLE       = 6'd0;
  localparam ua_t U_OK         = 6'd1;
  localparam ua_t U_BADPOS     = 6'd2;
  localparam ua_t U_FULL       = 6'd3;
  localparam ua_t U_NF         = 6'd4;
  localparam ua_t U_INS        = 6'd5;
  localparam ua_t U_INS_CHK    = 6'd6;
  localparam ua_t U_INS_LOOP   = 6'd7;
  localparam ua_t U_INS_RD     = 6'd8;
  localparam ua_t U_INS_WR     = 6'd9;
  localparam ua_t U_INS_PUT    = 6'd10;
  localparam ua_t U_DEL        = 6'd11;
  localparam ua_t U_RM         = 6'd12;
  localparam ua_t U_RM_RD      = 6'd13;
  localparam ua_t U_RM_WR      = 6'd14;
  localparam ua_t U_RM_END     = 6'd15;
  localparam ua_t U_DVAL       = 6'd16;
  localparam ua_t U_DV_LOOP    = 6'd17;
  localparam ua_t U_DV_RD      = 6'd18;
  localparam ua_t U_DV_CMP     = 6'd19;
  localparam ua_t U_DV_END     = 6'd20;
  localparam ua_t U_DV_GO      = 6'd21;
  localparam ua_t U_RD         = 6'd22;
  localparam ua_t U_RD_MEM     = 6'd23;
  localparam ua_t U_RD_EMIT    = 6'd24;
  localparam ua_t U_FIND       = 6'd25;
  localparam ua_t U_F_LOOP     = 6'd26;
  localparam ua_t U_F_RD       = 6'd27;
  localparam ua_t U_F_CMP      = 6'd28;
  localparam ua_t U_F_PEND     = 6'd29;
  localparam ua_t U_F_EMIT     = 6'd30;
  localparam ua_t U_F_MARK     = 6'd31;
  localparam ua_t U_F_INC      = 6'd32;
  localparam ua_t U_F_END      = 6'd33;
  localparam ua_t U_F_LAST     = 6'd34;
  localparam ua_t U_REV        = 6'd35;
  localparam ua_t U_REV_LOOP   = 6'd36;
  localparam ua_t U_REV_RD_LO  = 6'd37;
  localparam ua_t U_REV_RD_HI  = 6'd38;
  localparam ua_t U_REV_WR_LO  = 6'd39;
  localparam ua_t U_REV_WR_HI  = 6'd40;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    ua_t   target;
  } ucw_t;

  typedef struct packed {
    logic load;
    logic en;
    act_t act;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic ins_bad;
    logic badpos;
    logic idx_eq_ins;
    logic idx_p1_ge_cnt;
    logic idx_ge_cnt;
    logic nohit;
    logic nomatch;
    logic rev_done;
    logic out_busy;
  } flags_t;

  function automatic ucw_t ucode(input ua_t a);
    ucw_t w;
    case (a)
      U_IDLE:      w = '{ACT_NOP,            C_NEVER,         U_IDLE};
      U_OK:        w = '{ACT_EMIT_OK,        C_ALWAYS,        U_IDLE};
      U_BADPOS:    w = '{ACT_EMIT_BADPOS,    C_ALWAYS,        U_IDLE};
      U_FULL:      w = '{ACT_EMIT_FULL,      C_ALWAYS,        U_IDLE};
      U_NF:        w = '{ACT_EMIT_NF,        C_ALWAYS,        U_IDLE};
      U_INS:       w = '{ACT_SETUP_INS,      C_FULL,          U_FULL};
      U_INS_CHK:   w = '{ACT_NOP,            C_INS_BAD,       U_BADPOS};
      U_INS_LOOP:  w = '{ACT_NOP,            C_IDX_EQ_INS,    U_INS_PUT};
      U_INS_RD:    w = '{ACT_RD_IDX_M1,      C_NEVER,         U_IDLE};
      U_INS_WR:    w = '{ACT_WR_RD_DEC,      C_ALWAYS,        U_INS_LOOP};
      U_INS_PUT:   w = '{ACT_WR_VAL_INC,     C_ALWAYS,        U_OK};
      U_DEL:       w = '{ACT_SETUP_DEL,      C_BADPOS,        U_BADPOS};
      U_RM:        w = '{ACT_NOP,            C_IDX_P1_GE_CNT, U_RM_END};
      U_RM_RD:     w = '{ACT_RD_IDX_P1,      C_NEVER,         U_IDLE};
      U_RM_WR:     w = '{ACT_WR_RD_INC,      C_ALWAYS,        U_RM};
      U_RM_END:    w = '{ACT_DEC_CNT,        C_ALWAYS,        U_OK};
      U_DVAL:      w = '{ACT_CLR_SCAN,       C_NEVER,         U_IDLE};
      U_DV_LOOP:   w = '{ACT_NOP,            C_IDX_GE_CNT,    U_DV_END};
      U_DV_RD:     w = '{ACT_RD_IDX,         C_NEVER,         U_IDLE};
      U_DV_CMP:    w = '{ACT_CMP_INC,        C_ALWAYS,        U_DV_LOOP};
      U_DV_END:    w = '{ACT_SET_IDX_AT,     C_NOHIT,         U_NF};
      U_DV_GO:     w = '{ACT_NOP,            C_ALWAYS,        U_RM};
      U_RD:        w = '{ACT_NOP,            C_BADPOS,        U_BADPOS};
      U_RD_MEM:    w = '{ACT_RD_POS,         C_NEVER,         U_IDLE};
      U_RD_EMIT:   w = '{ACT_EMIT_READ,      C_ALWAYS,        U_IDLE};
      U_FIND:      w = '{ACT_CLR_SCAN,       C_NEVER,         U_IDLE};
      U_F_LOOP:    w = '{ACT_NOP,            C_IDX_GE_CNT,    U_F_END};
      U_F_RD:      w = '{ACT_RD_IDX,         C_NEVER,         U_IDLE};
      U_F_CMP:     w = '{ACT_NOP,            C_NOMATCH,       U_F_INC};
      U_F_PEND:    w = '{ACT_NOP,            C_NOHIT,         U_F_MARK};
      U_F_EMIT:    w = '{ACT_EMIT_FIND,      C_NEVER,         U_IDLE};
      U_F_MARK:    w = '{ACT_MARK_INC,       C_ALWAYS,        U_F_LOOP};
      U_F_INC:     w = '{ACT_INC_IDX,        C_ALWAYS,        U_F_LOOP};
      U_F_END:     w = '{ACT_NOP,            C_NOHIT,         U_NF};
      U_F_LAST:    w = '{ACT_EMIT_FIND_LAST, C_ALWAYS,        U_IDLE};
      U_REV:       w = '{ACT_SETUP_REV,      C_NEVER,         U_IDLE};
      U_REV_LOOP:  w = '{ACT_NOP,            C_REV_DONE,      U_OK};
      U_REV_RD_LO: w = '{ACT_DEC_HI_RD_IDX,  C_NEVER,         U_IDLE};
      U_REV_RD_HI: w = '{ACT_SAVE_RD_HI,     C_NEVER,         U_IDLE};
      U_REV_WR_LO: w = '{ACT_WR_IDX_RD,      C_NEVER,         U_IDLE};
      U_REV_WR_HI: w = '{ACT_WR_HI_TMP_INC,  C_ALWAYS,        U_REV_LOOP};
      default:     w = '{ACT_NOP,            C_ALWAYS,        U_IDLE};
    endcase
    return w;
  endfunction

  function automatic ua_t entry(input logic [OP_W-1:0] op);
    ua_t a;
    case (op)
      OP_INS_POS, OP_INS_FRONT, OP_INS_END: a = U_INS;
      OP_DEL_POS: a = U_DEL;
      OP_DEL_VAL: a = U_DVAL;
      OP_READ:    a = U_RD;
      OP_FIND:    a = U_FIND;
      default:    a = U_REV;
    endcase
    return a;
  endfunction

endpackage

// File: sv/oaee_seq.sv
// microcode sequencer: step counter, rom lookup, conditional jumps, dispatch
// depends on oaee_pkg
module oaee_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [oaee_pkg::OP_W-1:0]  in_operation,
  output logic                       in_ready,
  input  oaee_pkg::flags_t           flags,
  output oaee_pkg::ctrl_t            ctrl
);

  oaee_pkg::ua_t  upc_r;
  oaee_pkg::ua_t  upc_nxt;
  oaee_pkg::ucw_t uw;
  logic           idle;
  logic           is_emit;
  logic           stall;
  logic           cond_true;

  always_comb begin
    uw      = oaee_pkg::ucode(upc_r);
    idle    = (upc_r == oaee_pkg::U_IDLE);
    is_emit = uw.act inside {oaee_pkg::ACT_EMIT_OK, oaee_pkg::ACT_EMIT_BADPOS,
                             oaee_pkg::ACT_EMIT_FULL, oaee_pkg::ACT_EMIT_NF,
                             oaee_pkg::ACT_EMIT_READ, oaee_pkg::ACT_EMIT_FIND,
                             oaee_pkg::ACT_EMIT_FIND_LAST};
    stall   = is_emit && flags.out_busy;
    case (uw.cond)
      oaee_pkg::C_NEVER:         cond_true = 1'b0;
      oaee_pkg::C_ALWAYS:        cond_true = 1'b1;
      oaee_pkg::C_FULL:          cond_true = flags.full;
      oaee_pkg::C_INS_BAD:       cond_true = flags.ins_bad;
      oaee_pkg::C_BADPOS:        cond_true = flags.badpos;
      oaee_pkg::C_IDX_EQ_INS:    cond_true = flags.idx_eq_ins;
      oaee_pkg::C_IDX_P1_GE_CNT: cond_true = flags.idx_p1_ge_cnt;
      oaee_pkg::C_IDX_GE_CNT:    cond_true = flags.idx_ge_cnt;
      oaee_pkg::C_NOHIT:         cond_true = flags.nohit;
      oaee_pkg::C_NOMATCH:       cond_true = flags.nomatch;
      oaee_pkg::C_REV_DONE:      cond_true = flags.rev_done;
      default:                   cond_true = 1'b0;
    endcase

    if (idle) begin
      upc_nxt = in_valid ? oaee_pkg::entry(in_operation) : upc_r;
    end else if (stall) begin
      upc_nxt = upc_r;
    end else if (cond_true) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end

    in_ready  = idle;
    ctrl.load = idle && in_valid;
    ctrl.en   = !idle && !stall;
    ctrl.act  = uw.act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= oaee_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: sv/oaee_dp.sv
// datapath: element memory, pointers, count, match tracking, result register
// depends on oaee_pkg; driven by oaee_seq control words
module oaee_dp #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  oaee_pkg::ctrl_t                  ctrl,
  input  logic [oaee_pkg::OP_W-1:0]        in_operation,
  input  logic [oaee_pkg::POS_W-1:0]       in_position,
  input  logic signed [oaee_pkg::VAL_W-1:0] in_value,
  input  logic                             out_ready,
  output oaee_pkg::flags_t                 flags,
  output logic                             out_valid,
  output logic [oaee_pkg::ST_W-1:0]        out_status,
  output logic signed [oaee_pkg::VAL_W-1:0] out_read_value,
  output logic [oaee_pkg::POS_W-1:0]       out_found_position,
  output logic [oaee_pkg::POS_W-1:0]       out_element_count,
  output logic                             out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [oaee_pkg::VAL_W-1:0] mem [DEPTH];

  logic [oaee_pkg::OP_W-1:0]         op_r;
  logic [oaee_pkg::POS_W-1:0]        pos_r;
  logic signed [oaee_pkg::VAL_W-1:0] val_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] ins_r, ins_nxt;
  logic [CW-1:0] at_r, at_nxt;
  logic          hit_r, hit_nxt;
  logic signed [oaee_pkg::VAL_W-1:0] tmp_r, tmp_nxt;
  logic signed [oaee_pkg::VAL_W-1:0] rd_r;

  logic                              out_valid_r, out_valid_nxt;
  logic [oaee_pkg::ST_W-1:0]         out_status_r, out_status_nxt;
  logic signed [oaee_pkg::VAL_W-1:0] out_rv_r, out_rv_nxt;
  logic [oaee_pkg::POS_W-1:0]        out_fp_r, out_fp_nxt;
  logic [oaee_pkg::POS_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic signed [oaee_pkg::VAL_W-1:0] mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;

  logic [CW-1:0]                 idx_m1;
  logic [CW-1:0]                 idx_p1;
  logic [oaee_pkg::POS_W-1:0]    pos_m1;
  logic [oaee_pkg::POS_W-1:0]    cnt_ext;
  logic [oaee_pkg::POS_W-1:0]    at_p1;
  logic                          badpos;

  always_comb begin
    idx_m1  = idx_r - 1'b1;
    idx_p1  = idx_r + 1'b1;
    pos_m1  = pos_r - 1'b1;
    cnt_ext = oaee_pkg::POS_W'(cnt_r);
    at_p1   = oaee_pkg::POS_W'(at_r) + 1'b1;
    badpos  = (pos_r == '0) || (pos_r > cnt_ext);

    flags.full          = (cnt_r == CW'(DEPTH));
    flags.badpos        = badpos;
    flags.ins_bad       = (op_r == oaee_pkg::OP_INS_POS) && badpos;
    flags.idx_eq_ins    = (idx_r == ins_r);
    flags.idx_p1_ge_cnt = ({1'b0, idx_r} + 1'b1) >= {1'b0, cnt_r};
    flags.idx_ge_cnt    = (idx_r >= cnt_r);
    flags.nohit         = !hit_r;
    flags.nomatch       = (rd_r != val_r);
    flags.rev_done      = {1'b0, hi_r} <= ({1'b0, idx_r} + 1'b1);
    flags.out_busy      = out_valid_r && !out_ready;
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    hi_nxt         = hi_r;
    ins_nxt        = ins_r;
    at_nxt         = at_r;
    hit_nxt        = hit_r;
    tmp_nxt        = tmp_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = rd_r;
    mem_re         = 1'b0;
    mem_raddr      = idx_r[AW-1:0];
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_rv_nxt     = out_rv_r;
    out_fp_nxt     = out_fp_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;

    if (ctrl.en) begin
      case (ctrl.act)
        oaee_pkg::ACT_EMIT_OK, oaee_pkg::ACT_EMIT_BADPOS, oaee_pkg::ACT_EMIT_FULL,
        oaee_pkg::ACT_EMIT_NF: begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = '0;
          out_fp_nxt    = '0;
          out_cnt_nxt   = cnt_ext;
          out_last_nxt  = 1'b1;
          case (ctrl.act)
            oaee_pkg::ACT_EMIT_BADPOS: out_status_nxt = oaee_pkg::ST_BADPOS;
            oaee_pkg::ACT_EMIT_FULL:   out_status_nxt = oaee_pkg::ST_FULL;
            oaee_pkg::ACT_EMIT_NF:     out_status_nxt = oaee_pkg::ST_NOTFOUND;
            default:                   out_status_nxt = oaee_pkg::ST_OK;
          endcase
        end
        oaee_pkg::ACT_EMIT_READ: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = oaee_pkg::ST_OK;
          out_rv_nxt     = rd_r;
          out_fp_nxt     = '0;
          out_cnt_nxt    = cnt_ext;
          out_last_nxt   = 1'b1;
        end
        oaee_pkg::ACT_EMIT_FIND, oaee_pkg::ACT_EMIT_FIND_LAST: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = oaee_pkg::ST_OK;
          out_rv_nxt     = '0;
          out_fp_nxt     = at_p1;
          out_cnt_nxt    = cnt_ext;
          out_last_nxt   = (ctrl.act == oaee_pkg::ACT_EMIT_FIND_LAST);
        end
        oaee_pkg::ACT_SETUP_INS: begin
          idx_nxt = cnt_r;
          case (op_r)
            oaee_pkg::OP_INS_POS:   ins_nxt = CW'(pos_m1);
            oaee_pkg::OP_INS_FRONT: ins_nxt = '0;
            default:                ins_nxt = cnt_r;
          endcase
        end
        oaee_pkg::ACT_RD_IDX_M1: begin
          mem_re    = 1'b1;
          mem_raddr = idx_m1[AW-1:0];
        end
        oaee_pkg::ACT_WR_RD_DEC: begin
          mem_we  = 1'b1;
          idx_nxt = idx_m1;
        end
        oaee_pkg::ACT_WR_VAL_INC: begin
          mem_we    = 1'b1;
          mem_wdata = val_r;
          cnt_nxt   = cnt_r + 1'b1;
        end
        oaee_pkg::ACT_SETUP_DEL: begin
          idx_nxt = CW'(pos_m1);
        end
        oaee_pkg::ACT_RD_IDX_P1: begin
          mem_re    = 1'b1;
          mem_raddr = idx_p1[AW-1:0];
        end
        oaee_pkg::ACT_WR_RD_INC: begin
          mem_we  = 1'b1;
          idx_nxt = idx_p1;
        end
        oaee_pkg::ACT_DEC_CNT: begin
          cnt_nxt = cnt_r - 1'b1;
        end
        oaee_pkg::ACT_CLR_SCAN: begin
          idx_nxt = '0;
          hit_nxt = 1'b0;
        end
        oaee_pkg::ACT_RD_IDX: begin
          mem_re = 1'b1;
        end
        oaee_pkg::ACT_CMP_INC: begin
          if (rd_r == val_r) begin
            hit_nxt = 1'b1;
            at_nxt  = idx_r;
          end
          idx_nxt = idx_p1;
        end
        oaee_pkg::ACT_SET_IDX_AT: begin
          idx_nxt = at_r;
        end
        oaee_pkg::ACT_RD_POS: begin
          mem_re    = 1'b1;
          mem_raddr = pos_m1[AW-1:0];
        end
        oaee_pkg::ACT_MARK_INC: begin
          hit_nxt = 1'b1;
          at_nxt  = idx_r;
          idx_nxt = idx_p1;
        end
        oaee_pkg::ACT_INC_IDX: begin
          idx_nxt = idx_p1;
        end
        oaee_pkg::ACT_SETUP_REV: begin
          idx_nxt = '0;
          hi_nxt  = cnt_r;
        end
        oaee_pkg::ACT_DEC_HI_RD_IDX: begin
          hi_nxt = hi_r - 1'b1;
          mem_re = 1'b1;
        end
        oaee_pkg::ACT_SAVE_RD_HI: begin
          tmp_nxt   = rd_r;
          mem_re    = 1'b1;
          mem_raddr = hi_r[AW-1:0];
        end
        oaee_pkg::ACT_WR_IDX_RD: begin
          mem_we = 1'b1;
        end
        oaee_pkg::ACT_WR_HI_TMP_INC: begin
          mem_we    = 1'b1;
          mem_waddr = hi_r[AW-1:0];
          mem_wdata = tmp_r;
          idx_nxt   = idx_p1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value;
    end
    idx_r        <= idx_nxt;
    hi_r         <= hi_nxt;
    ins_r        <= ins_nxt;
    at_r         <= at_nxt;
    hit_r        <= hit_nxt;
    tmp_r        <= tmp_nxt;
    out_status_r <= out_status_nxt;
    out_rv_r     <= out_rv_nxt;
    out_fp_r     <= out_fp_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_rv_r;
  assign out_found_position = out_fp_r;
  assign out_element_count  = out_cnt_r;
  assign out_last           = out_last_r;

endmodule

// File: sv/ordered_array_edit_engine.sv
// one request at a time; in_ready is high only while the sequencer sits at its idle step
// insert and delete by position shift the later entries one at a time; delete value scans
// every entry and removes the last match; find scans every entry and gives one result per
// match, out_last on the final one; reverse swaps entry pairs from both ends inward
// every result step waits while the previous result is held by out_ready low
// synchronous active-low reset empties the array; stored entries are not cleared
`include "ordered_array_edit_engine_assert.svh"

module ordered_array_edit_engine #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [oaee_pkg::OP_W-1:0]         in_operation,
  input  logic [oaee_pkg::POS_W-1:0]        in_position,
  input  logic signed [oaee_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [oaee_pkg::ST_W-1:0]         out_status,
  output logic signed [oaee_pkg::VAL_W-1:0] out_read_value,
  output logic [oaee_pkg::POS_W-1:0]        out_found_position,
  output logic [oaee_pkg::POS_W-1:0]        out_element_count,
  output logic                              out_last
);

  oaee_pkg::ctrl_t  ctrl;
  oaee_pkg::flags_t flags;

  oaee_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .flags        (flags),
    .ctrl         (ctrl)
  );

  oaee_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_ready          (out_ready),
    .flags              (flags),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_element_count  (out_element_count),
    .out_last           (out_last)
  );

  `OAEE_ASSERT_NXT(a_leave_idle, in_valid && in_ready, !in_ready)
  `OAEE_ASSERT_IMP(a_no_work_idle, ctrl.en, !in_ready)
  `OAEE_ASSERT_IMP(a_count_range, out_valid, out_element_count <= oaee_pkg::POS_W'(DEPTH))
  `OAEE_ASSERT_IMP(a_partial_find, out_valid && !out_last,
                   out_status == oaee_pkg::ST_OK && out_found_position != '0)

endmodule
